[sv/matrix_graph_dfs_walker_macros.svh]
// Assertion macros for the matrix graph DFS walker.
// Bodies expect a clock named clk and an active-high reset named rst in scope.
`ifndef MATRIX_GRAPH_DFS_WALKER_MACROS_SVH
`define MATRIX_GRAPH_DFS_WALKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every clock edge outside reset.
`define MGDW_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MGDW_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MGDW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MGDW_ASSERT_ALWAYS(lbl, expr, msg)
`define MGDW_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define MGDW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/mgdw_pkg.sv]
// Package for the matrix graph DFS walker: item kinds, state codes, fixed widths.
// No dependencies.
package mgdw_pkg;

  localparam int          VCOUNT_W     = 7;
  localparam logic [6:0]  VCOUNT_RESET = 7'd64;
  localparam int          CAP_W        = 7;
  localparam logic [6:0]  RESULT_CAP   = 7'd64;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_WALK   = 2'd2;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_INS_RD    = 9'b000000010,
    S_INS_WR    = 9'b000000100,
    S_BAD       = 9'b000001000,
    S_POP       = 9'b000010000,
    S_POP_WAIT  = 9'b000100000,
    S_EMIT      = 9'b001000000,
    S_SCAN_LOAD = 9'b010000000,
    S_SCAN      = 9'b100000000
  } state_t;

endpackage

[sv/matrix_graph_dfs_walker.sv]
// Depth-first walker over an undirected adjacency bit matrix held in block memory.
// Depends on mgdw_pkg and matrix_graph_dfs_walker_macros.svh.
//
// Clear: done at acceptance by dropping every row valid flop. Insert: accept, then
//   read/write of row a and row b, all through the single adjacency memory.
// Walk: each stack pop passes S_POP and S_POP_WAIT; each visited vertex adds the row
//   fetch (S_EMIT, S_SCAN_LOAD) and the one-bit-per-cycle neighbor scan over n bits
//   (n = live vertex count); at most 1 + n*(n-1)/2 pops. The scan loop and the
//   stack memory port set the pace.
// Bad start: one result from S_BAD when the output is free. A walk's first result
//   leaves on the next vertex found or a drained stack, since last must be known.
// Reset (sync, active high): control cleared, all rows read as zero via per-row
//   valid flops, vertex_count = 64. No clearing pass; stack contents need none.
module matrix_graph_dfs_walker
  import mgdw_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic                clk,
  input  logic                rst,
  // configuration write
  input  logic                cfg_we,
  input  logic [VCOUNT_W-1:0] cfg_data,
  // input transactions
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          kind,
  input  logic [5:0]          vertex_a,
  input  logic [5:0]          vertex_b,
  // result transactions
  output logic                out_valid,
  input  logic                out_ready,
  output logic [5:0]          vertex,
  output logic                last,
  output logic                bad_start
);

`include "matrix_graph_dfs_walker_macros.svh"

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int CW    = ($clog2(MAX_VERTICES + 1) > VCOUNT_W) ?
                         $clog2(MAX_VERTICES + 1) : VCOUNT_W;
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int SAW   = $clog2(DEPTH);
  localparam int SPW   = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [VCOUNT_W-1:0] vertex_count;
  logic [CW-1:0]       live_n;
  logic                a_ok, b_ok;
  logic                in_fire, out_free;

  // insert bookkeeping
  logic [VW-1:0] ins_a, ins_b;
  logic          ins_second;

  // adjacency memory: one row per vertex, row valid flops give cleared rows
  logic [MAX_VERTICES-1:0] adj_mem [DEPTH / MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] adj_rdata, adj_wdata;
  logic                    adj_rvalid;
  logic                    adj_re, adj_we;
  logic [VW-1:0]           adj_raddr, adj_waddr;

  // pending-vertex stack memory
  logic [VW-1:0]  stack_mem [DEPTH];
  logic [VW-1:0]  stk_rdata, stk_wdata;
  logic           stk_re, stk_we;
  logic [SAW-1:0] stk_raddr, stk_waddr;
  logic [SPW-1:0] sp;

  // walk state
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] scan_bits;
  logic [CW-1:0]           scan_idx;
  logic [VW-1:0]           cur_v;
  logic [VW-1:0]           hold_v;
  logic                    hold_valid;
  logic [CAP_W-1:0]        emitted;
  logic                    walk_done;

  // result register load
  logic       out_load;
  logic [5:0] out_load_vertex;
  logic       out_load_last;
  logic       out_load_bad;

  assign live_n = (CW'(vertex_count) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                          : CW'(vertex_count);
  assign a_ok     = CW'(vertex_a) < live_n;
  assign b_ok     = CW'(vertex_b) < live_n;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // stack drained or cap reached: the held vertex is the last one
  assign walk_done = (sp == '0) || (emitted == RESULT_CAP);

  always_comb begin
    state_next      = state;
    adj_re          = 1'b0;
    adj_raddr       = cur_v;
    adj_we          = 1'b0;
    adj_waddr       = ins_second ? ins_b : ins_a;
    adj_wdata       = (adj_rvalid ? adj_rdata : '0) |
                      (MAX_VERTICES'(1) << (ins_second ? ins_a : ins_b));
    stk_re          = 1'b0;
    stk_raddr       = SAW'(sp - SPW'(1));
    stk_we          = 1'b0;
    stk_waddr       = SAW'(sp);
    stk_wdata       = VW'(scan_idx);
    out_load        = 1'b0;
    out_load_vertex = 6'(hold_v);
    out_load_last   = 1'b0;
    out_load_bad    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (kind)
            KIND_INSERT: begin
              if (a_ok && b_ok) state_next = S_INS_RD;
            end
            KIND_WALK: begin
              if (!a_ok) begin
                state_next = S_BAD;
              end else begin
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = VW'(vertex_a);
                state_next = S_POP;
              end
            end
            default: ;  // clear handled in the register block, kind 3 ignored
          endcase
        end
      end
      S_INS_RD: begin
        adj_re     = 1'b1;
        adj_raddr  = ins_second ? ins_b : ins_a;
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        adj_we     = 1'b1;
        state_next = ins_second ? S_IDLE : S_INS_RD;
      end
      S_BAD: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_load_vertex = '0;
          out_load_last   = 1'b1;
          out_load_bad    = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_POP: begin
        if (walk_done) begin
          // flush the held vertex with last set
          if (!hold_valid) begin
            state_next = S_IDLE;
          end else if (out_free) begin
            out_load      = 1'b1;
            out_load_last = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          stk_re     = 1'b1;
          state_next = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        state_next = visited[stk_rdata] ? S_POP : S_EMIT;
      end
      S_EMIT: begin
        if (!hold_valid || out_free) begin
          out_load   = hold_valid;
          adj_re     = 1'b1;
          state_next = S_SCAN_LOAD;
        end
      end
      S_SCAN_LOAD: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_bits[0] && (sp < SPW'(DEPTH))) stk_we = 1'b1;
        if (scan_idx == live_n - CW'(1)) state_next = S_POP;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= VCOUNT_RESET;
      row_valid    <= '0;
      ins_second   <= 1'b0;
      sp           <= '0;
      visited      <= '0;
      hold_valid   <= 1'b0;
      emitted      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) vertex_count <= cfg_data;
      if (adj_we) row_valid[adj_waddr] <= 1'b1;
      case (state)
        S_IDLE: begin
          ins_second <= 1'b0;
          if (in_fire && kind == KIND_CLEAR) row_valid <= '0;
          if (in_fire && kind == KIND_WALK) begin
            visited    <= '0;
            hold_valid <= 1'b0;
            emitted    <= '0;
            sp         <= SPW'(1);
          end
        end
        S_INS_WR: ins_second <= 1'b1;
        S_POP: begin
          if (stk_re) sp <= sp - SPW'(1);
          if (walk_done && out_load) hold_valid <= 1'b0;
        end
        S_EMIT: begin
          if (adj_re) begin
            visited[cur_v] <= 1'b1;
            hold_valid     <= 1'b1;
            emitted        <= emitted + CAP_W'(1);
          end
        end
        S_SCAN: if (stk_we) sp <= sp + SPW'(1);
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ins_a <= VW'(vertex_a);
      ins_b <= VW'(vertex_b);
    end
    if (state == S_POP_WAIT) cur_v <= stk_rdata;
    if (state == S_EMIT && adj_re) hold_v <= cur_v;
    if (state == S_SCAN_LOAD) begin
      scan_bits <= (adj_rvalid ? adj_rdata : '0) & ~visited;
      scan_idx  <= '0;
    end else if (state == S_SCAN) begin
      scan_bits <= scan_bits >> 1;
      scan_idx  <= scan_idx + CW'(1);
    end
  end

  // adjacency memory, registered read
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (adj_re) begin
      adj_rdata  <= adj_mem[adj_raddr];
      adj_rvalid <= row_valid[adj_raddr];
    end
  end

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata <= stack_mem[stk_raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vertex    <= out_load_vertex;
      last      <= out_load_last;
      bad_start <= out_load_bad;
    end
  end

  `MGDW_ASSERT_ALWAYS(a_sp_bound, sp <= SPW'(DEPTH), "stack pointer beyond stack depth")
  `MGDW_ASSERT_ALWAYS(a_cap_bound, emitted <= RESULT_CAP, "emitted count beyond cap")
  `MGDW_ASSERT_IMPLIES(a_bad_form, out_valid && bad_start, last && vertex == 6'd0,
                       "bad start result malformed")
  `MGDW_ASSERT_IMPLIES(a_scan_hold, state == S_SCAN || state == S_SCAN_LOAD, hold_valid,
                       "scanning without a held vertex")
  `MGDW_ASSERT_NEXT(a_final_last, state == S_POP && walk_done && hold_valid && out_free,
                    out_valid && last && state == S_IDLE, "walk end did not emit last")

endmodule
